[hw/rtl/qbs_pkg.sv]
// ----------------------------------------------------------------------------
// qbs_pkg
// Shared types and constants for the quantum barrier sync block.
// ----------------------------------------------------------------------------
package qbs_pkg;

    localparam int TIME_W        = 64;
    localparam int IV_W          = 32;
    localparam int CORE_W        = 4;
    localparam int MASK_BITS     = 16;
    localparam int NUM_CORES_DEF = 16;
    localparam int DIV_STEPS     = TIME_W;
    localparam int S_TDATA_W     = 88;
    localparam int M_TDATA_W     = 80;

    localparam logic [IV_W-1:0] IV_RESET = 32'd1000;

    localparam logic ACT_WAIT   = 1'b0;
    localparam logic ACT_SIGNAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_CHECK,
        ST_DECIDE,
        ST_CMP,
        ST_MOD,
        ST_CAND,
        ST_REL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic entry_write;
        logic set_imm;
        logic scan_start;
        logic scan_rel;
        logic adv_init;
        logic mod_start;
        logic mod_take;
        logic next_pass;
        logic nb_from_v;
        logic nb_fail;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_wait;
        logic core_ok;
        logic time_below;
        logic scan_done;
        logic reached;
        logic v_gt;
        logic mod_done;
        logic carry;
        logic pass;
    } t_sts;

    function automatic logic [IV_W-1:0] f_eff_iv(input logic [IV_W-1:0] iv);
        f_eff_iv = (iv == '0) ? IV_W'(1) : iv;
    endfunction

endpackage

[hw/rtl/qbs_mod.sv]
// ----------------------------------------------------------------------------
// qbs_mod
// Bit-serial remainder unit: 64-bit dividend modulo 32-bit divisor.
// ----------------------------------------------------------------------------
module qbs_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qbs_pkg::TIME_W-1:0] i_dividend,
    input  logic [qbs_pkg::IV_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [qbs_pkg::IV_W-1:0]   o_rem
);
    import qbs_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [IV_W-1:0]   r_rem;
    logic [IV_W-1:0]   r_div;
    logic [IV_W:0]     trial;
    logic              ge;
    logic [IV_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[TIME_W-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? IV_W'(trial - {1'b0, r_div}) : trial[IV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == SW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + SW'(1);
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

[hw/rtl/qbs_ctrl.sv]
// ----------------------------------------------------------------------------
// qbs_ctrl
// Sequencer for the barrier block: entry, check scan, advance, release, output.
// ----------------------------------------------------------------------------
module qbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  qbs_pkg::t_sts i_sts,
    output qbs_pkg::t_cmd o_cmd
);
    import qbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_mvalid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_ENTRY;
                end
            end
            ST_ENTRY: begin
                if (i_sts.is_wait) begin
                    if (!i_sts.core_ok) begin
                        n_state = ST_OUT;
                    end else if (i_sts.time_below) begin
                        cmd.set_imm = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        cmd.entry_write = 1'b1;
                        cmd.scan_start  = 1'b1;
                        n_state         = ST_CHECK;
                    end
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.reached) begin
                    cmd.adv_init = 1'b1;
                    n_state      = ST_CMP;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_CMP: begin
                if (i_sts.v_gt) begin
                    cmd.nb_from_v  = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_rel   = 1'b1;
                    n_state        = ST_REL;
                end else begin
                    cmd.mod_start = 1'b1;
                    n_state       = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_sts.mod_done) begin
                    cmd.mod_take = 1'b1;
                    n_state      = ST_CAND;
                end
            end
            ST_CAND: begin
                if (!i_sts.carry) begin
                    cmd.nb_from_v  = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_rel   = 1'b1;
                    n_state        = ST_REL;
                end else if (!i_sts.pass) begin
                    cmd.next_pass = 1'b1;
                    n_state       = ST_CMP;
                end else begin
                    cmd.nb_fail = 1'b1;
                    n_state     = ST_OUT;
                end
            end
            ST_REL: begin
                if (i_sts.scan_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_mvalid || i_m_tready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_cmd      = cmd;

    a_accept_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_ENTRY))
        else $error("accepted item did not enter decode");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_mvalid || i_m_tready))
        else $error("output register overwritten");

endmodule

[hw/rtl/qbs_datapath.sv]
// ----------------------------------------------------------------------------
// qbs_datapath
// Core clock memory, waiting flags, barrier time, scan and advance arithmetic.
// ----------------------------------------------------------------------------
module qbs_datapath #(
    parameter int NUM_CORES = qbs_pkg::NUM_CORES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qbs_pkg::t_cmd                i_cmd,
    output qbs_pkg::t_sts                o_sts,
    input  logic                         i_action,
    input  logic [qbs_pkg::CORE_W-1:0]   i_core,
    input  logic [qbs_pkg::TIME_W-1:0]   i_core_time,
    input  logic [qbs_pkg::MASK_BITS-1:0] i_running,
    input  logic                         i_cfg_we,
    input  logic [qbs_pkg::IV_W-1:0]     i_cfg_wdata,
    output logic [qbs_pkg::TIME_W-1:0]   o_mod_dvd,
    output logic [qbs_pkg::IV_W-1:0]     o_mod_div,
    input  logic                         i_mod_done,
    input  logic [qbs_pkg::IV_W-1:0]     i_mod_rem,
    output logic [qbs_pkg::MASK_BITS-1:0] o_mask,
    output logic [qbs_pkg::TIME_W-1:0]   o_barrier
);
    import qbs_pkg::*;

    localparam int IW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CW = $clog2(NUM_CORES + 1);

    logic [IV_W-1:0]      r_interval;
    logic [TIME_W-1:0]    r_nb;
    logic                 r_action;
    logic [CORE_W-1:0]    r_core;
    logic [TIME_W-1:0]    r_time;
    logic [MASK_BITS-1:0] r_running;

    logic [TIME_W-1:0]    r_mem [NUM_CORES];
    logic [NUM_CORES-1:0] r_vld;
    logic [NUM_CORES-1:0] r_wait;

    logic                 r_scan_act;
    logic                 r_scan_rel;
    logic [CW-1:0]        r_cnt;
    logic                 r_p_vld;
    logic [IW-1:0]        r_p_idx;
    logic [TIME_W-1:0]    r_p_data;
    logic                 r_p_ent;

    logic                 r_block;
    logic                 r_any;
    logic                 r_have;
    logic [TIME_W-1:0]    r_cmin;
    logic [MASK_BITS-1:0] r_mask;
    logic [TIME_W-1:0]    r_v;
    logic                 r_cy;
    logic                 r_pass;
    logic [MASK_BITS-1:0] r_out_mask;
    logic [TIME_W-1:0]    r_out_nb;

    logic [IV_W-1:0]      iv_eff;
    logic [TIME_W-1:0]    iv64;
    logic [IW-1:0]        wr_addr;
    logic [IW-1:0]        rd_addr;
    logic                 issue;
    logic                 scan_done;
    logic [TIME_W-1:0]    clk_v;
    logic                 below;
    logic                 waiting;
    logic [MASK_BITS-1:0] run_sh;
    logic                 rel_hit;

    always_comb begin
        iv_eff    = f_eff_iv(r_interval);
        iv64      = {{(TIME_W-IV_W){1'b0}}, iv_eff};
        wr_addr   = IW'(r_core);
        rd_addr   = r_cnt[IW-1:0];
        issue     = r_scan_act && (r_cnt != CW'(NUM_CORES));
        scan_done = r_scan_act && (r_cnt == CW'(NUM_CORES)) && !r_p_vld;
        clk_v     = r_p_ent ? r_p_data : '0;
        below     = clk_v < r_nb;
        waiting   = r_wait[r_p_idx];
        run_sh    = r_running >> r_p_idx;
        rel_hit   = r_p_vld && r_scan_rel && waiting && below;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IV_RESET;
            r_nb       <= {{(TIME_W-IV_W){1'b0}}, f_eff_iv(IV_RESET)};
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
            r_nb       <= {{(TIME_W-IV_W){1'b0}}, f_eff_iv(i_cfg_wdata)};
        end else if (i_cmd.nb_from_v) begin
            r_nb <= r_v;
        end else if (i_cmd.nb_fail) begin
            r_nb <= r_v - iv64;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_wait <= '0;
        end else if (i_cmd.entry_write) begin
            r_vld[wr_addr]  <= 1'b1;
            r_wait[wr_addr] <= 1'b1;
        end else if (rel_hit) begin
            r_wait[r_p_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_write) begin
            r_mem[wr_addr] <= r_time;
        end
        r_p_data <= r_mem[rd_addr];
        r_p_ent  <= r_vld[rd_addr];
        r_p_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act <= 1'b0;
            r_p_vld    <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_act <= 1'b1;
            r_p_vld    <= 1'b0;
        end else begin
            r_p_vld <= issue;
            if (scan_done) begin
                r_scan_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_cnt      <= '0;
            r_scan_rel <= i_cmd.scan_rel;
        end else if (issue) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_core    <= i_core;
            r_time    <= i_core_time;
            r_running <= i_running;
        end
        if (i_cmd.scan_start) begin
            r_block <= 1'b0;
            r_any   <= 1'b0;
            r_have  <= 1'b0;
            r_cmin  <= '1;
        end else if (r_p_vld && !r_scan_rel) begin
            if (below && run_sh[0]) begin
                r_block <= 1'b1;
            end
            if (!below) begin
                r_any <= 1'b1;
            end
            if (waiting && (!r_have || clk_v < r_cmin)) begin
                r_cmin <= clk_v;
                r_have <= 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_mask <= '0;
        end else if (i_cmd.set_imm) begin
            r_mask <= MASK_BITS'(1) << r_core;
        end else if (rel_hit) begin
            r_mask <= r_mask | (MASK_BITS'(1) << r_p_idx);
        end
        if (i_cmd.adv_init) begin
            r_v    <= r_nb + iv64;
            r_cy   <= 1'b0;
            r_pass <= 1'b0;
        end else if (i_cmd.mod_take) begin
            {r_cy, r_v} <= {1'b0, r_cmin} + {{(TIME_W-IV_W+1){1'b0}}, iv_eff - i_mod_rem};
        end else if (i_cmd.next_pass) begin
            r_pass <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_mask <= r_mask;
            r_out_nb   <= r_nb;
        end
    end

    always_comb begin
        o_sts.is_wait    = (r_action == ACT_WAIT);
        o_sts.core_ok    = 32'(r_core) < NUM_CORES;
        o_sts.time_below = r_time < r_nb;
        o_sts.scan_done  = scan_done;
        o_sts.reached    = !r_block && r_any && r_have;
        o_sts.v_gt       = r_v > r_cmin;
        o_sts.mod_done   = i_mod_done;
        o_sts.carry      = r_cy;
        o_sts.pass       = r_pass;
    end

    assign o_mod_dvd = r_cmin - r_v;
    assign o_mod_div = iv_eff;
    assign o_mask    = r_out_mask;
    assign o_barrier = r_out_nb;

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.entry_write |-> (o_sts.core_ok && !o_sts.time_below))
        else $error("clock recorded for a released or unknown core");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_start |-> !r_scan_act)
        else $error("remainder started during a scan");

endmodule

[hw/rtl/quantum_barrier_sync.sv]
// ----------------------------------------------------------------------------
// quantum_barrier_sync
// Quantum barrier for up to NUM_CORES cores. A wait item below the barrier
// time goes from entry decode straight to the output state, where its result
// is loaded into the output register; so does a wait item for an unknown core.
// Every other item runs a scan of the core clock memory, one entry per cycle;
// when the barrier is reached the barrier time is advanced with a bit-serial
// remainder unit (at most two passes) and, unless the advance fails, a second
// scan releases the waiting cores. An item may also wait for a full output
// register to drain; the next item is taken once the previous one is finished,
// while its result may still sit in the output register.
// ----------------------------------------------------------------------------
module quantum_barrier_sync #(
    parameter int NUM_CORES = qbs_pkg::NUM_CORES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // core[3:0], core_time[67:4], running_mask[83:68], zero fill
    input  logic [qbs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // release_mask[15:0], barrier_time[79:16]
    output logic [qbs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [qbs_pkg::IV_W-1:0]      i_cfg_wdata
);
    import qbs_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [TIME_W-1:0]    mod_dvd;
    logic [IV_W-1:0]      mod_div;
    logic                 mod_done;
    logic [IV_W-1:0]      mod_rem;
    logic [MASK_BITS-1:0] out_mask;
    logic [TIME_W-1:0]    out_nb;

    qbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qbs_datapath #(
        .NUM_CORES (NUM_CORES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (s_axis_tuser[0]),
        .i_core      (s_axis_tdata[3:0]),
        .i_core_time (s_axis_tdata[67:4]),
        .i_running   (s_axis_tdata[83:68]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mod_dvd   (mod_dvd),
        .o_mod_div   (mod_div),
        .i_mod_done  (mod_done),
        .i_mod_rem   (mod_rem),
        .o_mask      (out_mask),
        .o_barrier   (out_nb)
    );

    qbs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cmd.mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (mod_div),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign m_axis_tdata = {out_nb, out_mask};

endmodule

[test/quantum_barrier_sync_test.sv]
// ----------------------------------------------------------------------------
// quantum_barrier_sync_test
// Self-checking bench for the quantum barrier block. A directed table walks
// immediate releases, barrier advances, the zero interval, a barrier reached
// with nothing waiting and clocks the barrier can never pass; random rounds of
// mostly wait items from running cores, with random items and signals, follow
// under several intervals and idling patterns. Each result is checked against
// the row's values or a barrier predictor kept in step with accepted items.
// ----------------------------------------------------------------------------
module quantum_barrier_sync_test;
    import qbs_pkg::*;

    localparam int NCORE          = 16;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int PHASES         = 8;
    localparam int DIR_ROWS_N     = 16;
    localparam int DRAIN_CYCLES   = 2 * NCORE + 170;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [0:0] {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        act;
        logic [3:0]  core;
        logic [63:0] tm;
        logic [15:0] run;
        logic        typed;
        logic [15:0] rel;
        logic [63:0] bt;
    } t_dir_row;

    typedef struct packed {
        logic [15:0] rel;
        logic [63:0] bt;
    } t_release;

    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{ROW_ITEM, ACT_WAIT,   4'd0,  64'd0,     16'h0001, 1'b1, 16'h0001, 64'd1000},
        '{ROW_ITEM, ACT_WAIT,   4'd15, 64'd999,   16'hFFFF, 1'b1, 16'h8000, 64'd1000},
        '{ROW_ITEM, ACT_SIGNAL, 4'd0,  64'd0,     16'h0000, 1'b1, 16'h0000, 64'd1000},
        '{ROW_ITEM, ACT_SIGNAL, 4'd0,  64'd0,     16'hFFFF, 1'b1, 16'h0000, 64'd1000},
        '{ROW_ITEM, ACT_WAIT,   4'd3,  64'd1000,  16'h0008, 1'b0, 16'h0000, 64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd9,  64'd12345, 16'h0000, 1'b0, 16'h0000, 64'd0},
        '{ROW_CFG,  ACT_WAIT,   4'd0,  64'd0,     16'h0000, 1'b0, 16'h0000, 64'd0},
        '{ROW_ITEM, ACT_SIGNAL, 4'd0,  64'd0,     16'h0208, 1'b0, 16'h0000, 64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd5,  T_MAX,     16'h0020, 1'b0, 16'h0000, 64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd7,  64'd5,     16'hFFFF, 1'b1, 16'h0080, T_MAX},
        '{ROW_CFG,  ACT_WAIT,   4'd0,  64'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000, 64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd1,  64'hFFFF_FFFF_0000_0000, 16'h0002, 1'b0, 16'h0000,
          64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd10, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b0, 16'h0000,
          64'd0},
        '{ROW_ITEM, ACT_SIGNAL, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b0, 16'h0000,
          64'd0},
        '{ROW_ITEM, ACT_WAIT,   4'd5,  64'd0,     16'h0000, 1'b0, 16'h0000, 64'd0},
        '{ROW_CFG,  ACT_WAIT,   4'd0,  64'd1000,  16'h0000, 1'b0, 16'h0000, 64'd0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [IV_W-1:0]      i_cfg_wdata   = '0;

    logic [63:0]     core_clk [NCORE];
    logic            core_wait [NCORE];
    logic [63:0]     next_bt;
    logic [IV_W-1:0] cur_iv;

    t_release pending_releases [$];
    int       err_count   = 0;
    int       items_sent  = 0;
    int       src_idle    = 0;
    int       snk_stall   = 0;
    int       idle_cycles = 0;

    quantum_barrier_sync u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] eff_interval();
        return (cur_iv == '0) ? 64'd1 : {32'd0, cur_iv};
    endfunction

    function automatic bit barrier_is_reached(logic [15:0] run);
        bit any_at = 1'b0;
        for (int i = 0; i < NCORE; i++) begin
            if (core_clk[i] < next_bt) begin
                if (i < MASK_BITS && run[i]) return 1'b0;
            end else begin
                any_at = 1'b1;
            end
        end
        return any_at;
    endfunction

    function automatic bit scan_pass(input logic [63:0] v0, input logic [63:0] iv,
                                     input logic [63:0] lim, output logic [63:0] hit,
                                     output logic [63:0] last);
        logic [63:0] jmax;
        logic [63:0] q;
        hit  = v0;
        last = v0;
        if (v0 > lim) return 1'b1;
        jmax = (T_MAX - v0) / iv;
        q    = (lim - v0) / iv;
        if (q < jmax) begin
            hit = v0 + (q + 64'd1) * iv;
            return 1'b1;
        end
        last = v0 + jmax * iv;
        return 1'b0;
    endfunction

    function automatic logic [15:0] release_waiting();
        logic [63:0] iv   = eff_interval();
        logic [63:0] cmin = T_MAX;
        logic [63:0] v;
        logic [63:0] hit  = '0;
        logic [63:0] last = '0;
        logic [15:0] rel  = '0;
        bit          have  = 1'b0;
        bit          found = 1'b0;
        for (int i = 0; i < NCORE; i++) begin
            if (core_wait[i] && (!have || core_clk[i] < cmin)) begin
                cmin = core_clk[i];
                have = 1'b1;
            end
        end
        if (!have) return '0;
        v = next_bt + iv;
        for (int p = 0; p < 2 && !found; p++) begin
            found = scan_pass(v, iv, cmin, hit, last);
            if (!found) v = last + iv;
        end
        if (!found) begin
            next_bt = last;
            return '0;
        end
        next_bt = hit;
        for (int i = 0; i < NCORE; i++) begin
            if (core_wait[i] && core_clk[i] < next_bt) begin
                core_wait[i] = 1'b0;
                if (i < MASK_BITS) rel[i] = 1'b1;
            end
        end
        return rel;
    endfunction

    function automatic t_release step_barrier(logic act, logic [3:0] core, logic [63:0] tm,
                                              logic [15:0] run);
        t_release r;
        r.rel = '0;
        if (act == ACT_WAIT) begin
            if (tm < next_bt) begin
                r.rel[core] = 1'b1;
            end else begin
                core_clk[core]  = tm;
                core_wait[core] = 1'b1;
                if (barrier_is_reached(run)) r.rel = release_waiting();
            end
        end else if (barrier_is_reached(run)) begin
            r.rel = release_waiting();
        end
        r.bt = next_bt;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic push_item(input logic act, input logic [3:0] core, input logic [63:0] tm,
                             input logic [15:0] run, input logic typed,
                             input logic [15:0] want_rel, input logic [63:0] want_bt);
        t_release r;
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'd0, run, tm, core};
        do @(posedge i_clk); while (!s_axis_tready);
        r = step_barrier(act, core, tm, run);
        if (typed) begin
            r.rel = want_rel;
            r.bt  = want_bt;
        end
        pending_releases.push_back(r);
        items_sent++;
    endtask

    task automatic write_interval(input logic [IV_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_releases.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_iv  = val;
        next_bt = eff_interval();
    endtask

    task automatic run_round();
        logic [15:0] run;
        logic [15:0] item_run;
        logic [63:0] ivx;
        logic [63:0] tm;
        logic [3:0]  c;
        int          start;
        int          pick;
        ivx   = eff_interval();
        start = $urandom_range(NCORE - 1);
        case ($urandom_range(3))
            0:       run = 16'hFFFF;
            1:       run = 16'hFFFF >> $urandom_range(15);
            default: run = 16'($urandom) | 16'(1 << $urandom_range(15));
        endcase
        for (int k = 0; k < NCORE; k++) begin
            c        = 4'(start + k);
            pick     = $urandom_range(99);
            item_run = ($urandom_range(19) == 0) ? run ^ 16'(1 << $urandom_range(15)) : run;
            if (!run[c]) begin
                // skip idle cores
            end else if (pick < 8) begin
                tm = ($urandom_range(3) == 0) ? T_MAX - 64'($urandom_range(4095))
                                              : {$urandom, $urandom};
                push_item(1'($urandom), 4'($urandom), tm, 16'($urandom), 1'b0, '0, '0);
            end else if (pick < 18) begin
                push_item(ACT_WAIT, c, next_bt - 64'($urandom_range(1, 40)), item_run,
                          1'b0, '0, '0);
            end else if (pick >= 24) begin
                tm = next_bt + ivx * 64'($urandom_range(3)) + (64'($urandom) % ivx);
                push_item(ACT_WAIT, c, tm, item_run, 1'b0, '0, '0);
            end
        end
        if ($urandom_range(3) == 0) begin
            push_item(ACT_SIGNAL, 4'($urandom), {$urandom, $urandom}, run, 1'b0, '0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end

    always @(posedge i_clk) begin
        t_release want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_releases.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = pending_releases.pop_front();
                if (m_axis_tdata[15:0] !== want.rel)
                    report_mismatch($sformatf("release_mask got %h want %h",
                                              m_axis_tdata[15:0], want.rel));
                if (m_axis_tdata[79:16] !== want.bt)
                    report_mismatch($sformatf("barrier_time got %h want %h",
                                              m_axis_tdata[79:16], want.bt));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quantum_barrier_sync_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [IV_W-1:0] iv_sel;
        for (int i = 0; i < NCORE; i++) begin
            core_clk[i]  = '0;
            core_wait[i] = 1'b0;
        end
        cur_iv  = IV_RESET;
        next_bt = eff_interval();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS_N; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                write_interval(DIR_ROWS[r].tm[IV_W-1:0]);
            end else begin
                push_item(DIR_ROWS[r].act, DIR_ROWS[r].core, DIR_ROWS[r].tm, DIR_ROWS[r].run,
                          DIR_ROWS[r].typed, DIR_ROWS[r].rel, DIR_ROWS[r].bt);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       iv_sel = 32'd1;
                1:       iv_sel = 32'hFFFF_FFFF;
                2:       iv_sel = 32'd0;
                3:       iv_sel = IV_RESET;
                4:       iv_sel = 32'd7;
                6:       iv_sel = 32'($urandom_range(2, 5000));
                default: iv_sel = $urandom;
            endcase
            write_interval(iv_sel);
            case (ph % 4)
                0:       begin src_idle = 0;  snk_stall = 0;  end
                1:       begin src_idle = 47; snk_stall = 0;  end
                2:       begin src_idle = 0;  snk_stall = 47; end
                default: begin src_idle = 10; snk_stall = 10; end
            endcase
            while (items_sent < DIR_ROWS_N + (ph + 1) * RANDOM_ITEMS / PHASES) run_round();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_releases.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("quantum_barrier_sync_test: done, clean");
        end else begin
            $display("quantum_barrier_sync_test: done, errors");
        end
        $finish;
    end

endmodule
